// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define FHCE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression never holds at a clock edge outside reset.
`define FHCE_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/fhce_pkg.sv -----
package fhce_pkg;

  localparam int NUM_BINS_DEF    = 128;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int NUM_CLASSES     = 3;

  localparam int LEN_W     = 7;
  localparam int SAMPLE_W  = 8;
  localparam int BOUND_W   = 16;
  localparam int MULT_W    = 3;
  localparam int MULT_X_W  = 4;
  localparam int RANGE_W   = 9;
  localparam int CLASS_W   = 31;
  localparam int WSUM_W    = 46;
  localparam int DIV_W     = 36;
  localparam int CELL_W    = 18;
  localparam int CLS_IDX_W = 2;
  localparam int REG_IDX_W = 3;

  localparam int BIN_SHIFT = 8;
  localparam logic [BOUND_W-1:0] BOUND_ROUND = 16'h00ff;

  localparam logic [CLASS_W-1:0] CLASS_MAX = 31'h7fff_ffff;
  localparam logic [WSUM_W-1:0]  WSUM_MAX  = 46'h3fff_ffff_ffff;
  localparam logic [CELL_W-1:0]  CELL_MAX  = 18'h3_ffff;
  localparam logic [MULT_W-1:0]  MULT_START_RESET = 3'd2;

  localparam logic [REG_IDX_W-1:0] REG_LOW_BOUND_0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_BOUND_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_BOUND_1  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_BOUND_1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOW_BOUND_2  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_BOUND_2 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MULT_START   = 3'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [RANGE_W-1:0] round_bound(input logic [BOUND_W-1:0] b);
    logic [BOUND_W:0] s;
    s = {1'b0, b} + {1'b0, BOUND_ROUND};
    return RANGE_W'(s >> BIN_SHIFT);
  endfunction

endpackage

// ----- hw/rtl/fhce_div.sv -----
module fhce_div #(
  parameter int DIVIDEND_W = fhce_pkg::WSUM_W,
  parameter int DIVISOR_W  = fhce_pkg::DIV_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output fhce_pkg::div_status_t status,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quot;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign shifted = {rem, quot[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIVIDEND_W-2:0], fits};
      rem  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quot;

endmodule

// ----- hw/rtl/flux_histogram_cell_estimator.sv -----
// Flux pulse histogram and cell length estimator.
// Sample channel: one beat per flux byte (sample, last). Beats with last low
// add the low 7 bits of sample to a bin histogram held in one block RAM, one
// beat per cycle while sample_stall is low; a beat whose pulse length falls
// beyond the bin count is dropped. A beat with last high closes the block: it
// is not counted, and it starts the analysis, during which sample_stall stays
// high. Analysis: a setup state, then one RAM read per cycle over each class
// range, a drain state until the scan pipeline is empty, a state that forms
// the divisor, 46 shift-subtract steps, and the quotient taken into the
// first result beat.
// Result channel: three beats (class 0, 1, 2), the third with last_result
// set. A stalled beat holds its payload; the next class follows in the cycle
// after each accepted beat. The histogram is cleared through per-bin valid
// bits when the divide finishes, and sample_stall drops after the third beat.
// Reset clears the histogram, the control state and the configuration
// registers (mult_start resets to 2); no clearing pass is needed.
// Configuration writes are registered and are meant for idle periods.
module flux_histogram_cell_estimator #(
  parameter int NUM_BINS    = fhce_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = fhce_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fhce_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [fhce_pkg::BOUND_W-1:0]         cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic [fhce_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                 last,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [fhce_pkg::CLS_IDX_W-1:0]       class_index,
  output logic [fhce_pkg::CELL_W-1:0]          cell_length,
  output logic                                 no_data,
  output logic                                 last_result
);

  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int PROD_W   = BIN_W + COUNT_WIDTH;
  localparam int WPROD_W  = PROD_W + fhce_pkg::BIN_SHIFT;
  localparam int ADD_W    = (WPROD_W > fhce_pkg::WSUM_W ? WPROD_W : fhce_pkg::WSUM_W) + 1;
  localparam int CC_ADD_W = (COUNT_WIDTH > fhce_pkg::CLASS_W ?
                             COUNT_WIDTH : fhce_pkg::CLASS_W) + 1;
  localparam int RW       = fhce_pkg::RANGE_W;
  localparam int CW       = fhce_pkg::CLS_IDX_W;
  localparam int MXW      = fhce_pkg::MULT_X_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_DIVSET = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  localparam logic [CW-1:0] LAST_CLASS = CW'(fhce_pkg::NUM_CLASSES - 1);

  // configuration
  logic [fhce_pkg::BOUND_W-1:0] low_bound_0, high_bound_0;
  logic [fhce_pkg::BOUND_W-1:0] low_bound_1, high_bound_1;
  logic [fhce_pkg::BOUND_W-1:0] low_bound_2, high_bound_2;
  logic [fhce_pkg::MULT_W-1:0]  mult_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound_0  <= '0;
      high_bound_0 <= '0;
      low_bound_1  <= '0;
      high_bound_1 <= '0;
      low_bound_2  <= '0;
      high_bound_2 <= '0;
      mult_start   <= fhce_pkg::MULT_START_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fhce_pkg::REG_LOW_BOUND_0:  low_bound_0  <= cfg_data;
        fhce_pkg::REG_HIGH_BOUND_0: high_bound_0 <= cfg_data;
        fhce_pkg::REG_LOW_BOUND_1:  low_bound_1  <= cfg_data;
        fhce_pkg::REG_HIGH_BOUND_1: high_bound_1 <= cfg_data;
        fhce_pkg::REG_LOW_BOUND_2:  low_bound_2  <= cfg_data;
        fhce_pkg::REG_HIGH_BOUND_2: high_bound_2 <= cfg_data;
        fhce_pkg::REG_MULT_START:   mult_start   <= cfg_data[fhce_pkg::MULT_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  logic [2:0]    state;
  logic [CW-1:0] cls;
  logic [RW-1:0] scan_bin;
  logic [RW-1:0] scan_hi;
  logic [CW-1:0] emit_idx;

  // histogram memory
  logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_valid;
  logic                   rd_en;
  logic [BIN_W-1:0]       rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_vld;
  logic                   hist_clear;

  // sample update stage
  localparam int SAMPLE_W_L = fhce_pkg::SAMPLE_W;

  logic                   sample_acc;
  logic                   count_acc;
  logic                   last_acc;
  logic [SAMPLE_W_L-1:0]  len_ext;
  logic                   len_in_range;
  logic                   s1_valid;
  logic [BIN_W-1:0]       s1_addr;
  logic                   fwd_valid;
  logic [BIN_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] new_count;

  // scan pipeline
  logic                   scan_active;
  logic                   p1_valid;
  logic [BIN_W-1:0]       p1_bin;
  logic [CW-1:0]          p1_cls;
  logic [COUNT_WIDTH-1:0] p1_count;
  logic                   p2_valid;
  logic [COUNT_WIDTH-1:0] p2_count;
  logic [PROD_W-1:0]      p2_prod;
  logic [CW-1:0]          p2_cls;

  logic [fhce_pkg::WSUM_W-1:0]  wsum;
  logic [ADD_W-1:0]             wsum_sum;
  logic [fhce_pkg::CLASS_W-1:0] class_cnt [fhce_pkg::NUM_CLASSES];
  logic [CC_ADD_W-1:0]          cc_sum;

  // bound selection
  logic [CW-1:0]                cls_load;
  logic [fhce_pkg::BOUND_W-1:0] lo_sel;
  logic [fhce_pkg::BOUND_W-1:0] hi_sel;

  // divide
  logic [MXW-1:0]               m0, m1, m2;
  logic [fhce_pkg::DIV_W-1:0]   divisor;
  logic                         div_start;
  fhce_pkg::div_status_t        div_status;
  logic [fhce_pkg::WSUM_W-1:0]  quotient;
  logic [fhce_pkg::WSUM_W-1:0]  base;
  logic [fhce_pkg::WSUM_W-1:0]  base_new;
  logic                         nodata;
  logic [CW-1:0]                emit_next;
  logic [MXW-1:0]               m_next;

  function automatic logic [fhce_pkg::CELL_W-1:0] cell_of(
    input logic [fhce_pkg::WSUM_W-1:0] b,
    input logic [MXW-1:0]              m
  );
    logic [fhce_pkg::CELL_W+MXW-1:0] prod;
    logic                            big;
    prod = m * b[fhce_pkg::CELL_W-1:0];
    big  = |b[fhce_pkg::WSUM_W-1:fhce_pkg::CELL_W];
    if (m == '0) return '0;
    else if (big) return fhce_pkg::CELL_MAX;
    else if (prod > (fhce_pkg::CELL_W+MXW)'(fhce_pkg::CELL_MAX)) return fhce_pkg::CELL_MAX;
    else return prod[fhce_pkg::CELL_W-1:0];
  endfunction

  assign sample_stall = (state != ST_IDLE);
  assign sample_acc   = sample_valid && !sample_stall;
  assign len_ext      = {1'b0, sample[fhce_pkg::LEN_W-1:0]};
  assign len_in_range = {1'b0, len_ext} < (SAMPLE_W_L+1)'(NUM_BINS);
  assign count_acc    = sample_acc && !last && len_in_range;
  assign last_acc     = sample_acc && last;

  assign scan_active = (state == ST_SCAN) && (scan_bin <= scan_hi)
                       && (scan_bin < RW'(NUM_BINS));

  assign rd_en   = count_acc || scan_active;
  assign rd_addr = scan_active ? scan_bin[BIN_W-1:0] : len_ext[BIN_W-1:0];

  assign cur_count = (fwd_valid && fwd_addr == s1_addr) ? fwd_data :
                     (rd_vld ? rd_data : '0);
  assign new_count = (&cur_count) ? cur_count : cur_count + 1'b1;

  assign hist_clear = (state == ST_DIV) && div_status.done;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      bin_mem[s1_addr] <= new_count;
    end
    if (rd_en) begin
      rd_data <= bin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || hist_clear) begin
      bin_valid <= '0;
    end else if (s1_valid) begin
      bin_valid[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld <= bin_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= count_acc;
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= len_ext[BIN_W-1:0];
    fwd_addr <= s1_addr;
    fwd_data <= new_count;
  end

  // scan pipeline: read, multiply, accumulate
  assign p1_count = rd_vld ? rd_data : '0;
  assign wsum_sum = ADD_W'(wsum) + (ADD_W'(p2_prod) << fhce_pkg::BIN_SHIFT);
  assign cc_sum   = CC_ADD_W'(class_cnt[p2_cls]) + CC_ADD_W'(p2_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= scan_active;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_bin   <= scan_bin[BIN_W-1:0];
    p1_cls   <= cls;
    p2_count <= p1_count;
    p2_prod  <= p1_bin * p1_count;
    p2_cls   <= p1_cls;
    if (state == ST_SETUP) begin
      wsum <= '0;
      for (int i = 0; i < fhce_pkg::NUM_CLASSES; i++) begin
        class_cnt[i] <= '0;
      end
    end else if (p2_valid) begin
      wsum <= (wsum_sum >= ADD_W'(fhce_pkg::WSUM_MAX)) ? fhce_pkg::WSUM_MAX :
              wsum_sum[fhce_pkg::WSUM_W-1:0];
      class_cnt[p2_cls] <= (cc_sum >= CC_ADD_W'(fhce_pkg::CLASS_MAX)) ?
                           fhce_pkg::CLASS_MAX : cc_sum[fhce_pkg::CLASS_W-1:0];
    end
  end

  // bounds of the class being loaded
  assign cls_load = (state == ST_SETUP) ? '0 : cls + 1'b1;

  always_comb begin
    unique case (cls_load)
      2'd0: begin
        lo_sel = low_bound_0;
        hi_sel = high_bound_0;
      end
      2'd1: begin
        lo_sel = low_bound_1;
        hi_sel = high_bound_1;
      end
      default: begin
        lo_sel = low_bound_2;
        hi_sel = high_bound_2;
      end
    endcase
  end

  // divisor and divide
  assign m0 = {1'b0, mult_start};
  assign m1 = m0 + 1'b1;
  assign m2 = m0 + 2'd2;
  assign divisor = fhce_pkg::DIV_W'(m0 * class_cnt[0])
                 + fhce_pkg::DIV_W'(m1 * class_cnt[1])
                 + fhce_pkg::DIV_W'(m2 * class_cnt[2]);
  assign div_start = (state == ST_DIVSET);

  fhce_div #(
    .DIVIDEND_W(fhce_pkg::WSUM_W),
    .DIVISOR_W (fhce_pkg::DIV_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(wsum),
    .divisor (divisor),
    .status  (div_status),
    .quotient(quotient)
  );

  assign base_new  = nodata ? '0 : quotient;
  assign emit_next = emit_idx + 1'b1;
  assign m_next    = m0 + MXW'(emit_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      emit_idx     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (last_acc) state <= ST_SETUP;
        end
        ST_SETUP: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!scan_active && cls == LAST_CLASS) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!p1_valid && !p2_valid) state <= ST_DIVSET;
        end
        ST_DIVSET: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_status.done) begin
            state        <= ST_EMIT;
            result_valid <= 1'b1;
            emit_idx     <= '0;
          end
        end
        ST_EMIT: begin
          if (result_valid && !result_stall) begin
            if (emit_idx == LAST_CLASS) begin
              result_valid <= 1'b0;
              state        <= ST_IDLE;
            end else begin
              emit_idx <= emit_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SETUP || (state == ST_SCAN && !scan_active && cls != LAST_CLASS)) begin
      cls      <= cls_load;
      scan_bin <= fhce_pkg::round_bound(lo_sel);
      scan_hi  <= fhce_pkg::round_bound(hi_sel);
    end else if (scan_active) begin
      scan_bin <= scan_bin + 1'b1;
    end
    if (state == ST_DIVSET) begin
      nodata <= (divisor == '0);
    end
    if (state == ST_DIV && div_status.done) begin
      base        <= base_new;
      cell_length <= cell_of(base_new, m0);
    end else if (state == ST_EMIT && result_valid && !result_stall
                 && emit_idx != LAST_CLASS) begin
      cell_length <= cell_of(base, m_next);
    end
  end

  assign class_index = emit_idx;
  assign no_data     = nodata;
  assign last_result = (emit_idx == LAST_CLASS);

endmodule

// ----- hw/rtl/fhce_checker.sv -----
`include "assert_macros.svh"

module fhce_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [fhce_pkg::CLS_IDX_W-1:0] class_index,
  input logic [fhce_pkg::CELL_W-1:0]    cell_length,
  input logic                           no_data,
  input logic                           last_result
);

  `FHCE_ASSERT(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(class_index) && $stable(cell_length) && $stable(no_data), "stalled result beat changed")
  `FHCE_ASSERT(a_last_tag, clk, rst, result_valid |-> (last_result == (class_index == 2'd2)), "last_result not on third class")
  `FHCE_ASSERT(a_nodata_zero, clk, rst, result_valid && no_data |-> cell_length == '0, "no_data beat with nonzero cell length")
  `FHCE_ASSERT(a_block_end, clk, rst, result_valid && !result_stall && last_result |=> !result_valid, "result beat after last_result")
  `FHCE_ASSERT_NEVER(a_busy_stall, clk, rst, result_valid && !sample_stall, "samples taken while results pending")

endmodule

bind flux_histogram_cell_estimator fhce_checker u_fhce_checker (.*);

// ----- sim/tb_flux_histogram_cell_estimator.sv -----
`timescale 1ns / 1ps

module tb_flux_histogram_cell_estimator;

  localparam int CLK_HALF    = 10;
  localparam int NUM_BINS    = fhce_pkg::NUM_BINS_DEF;
  localparam int COUNT_WIDTH = fhce_pkg::COUNT_WIDTH_DEF;
  localparam int IDLE_PCT    = 23;
  localparam int SETTLE      = 8;
  localparam int TAIL_CYCLES = 60;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [fhce_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint unsigned COUNT_SAT = (64'd1 << COUNT_WIDTH) - 1;

  typedef struct {
    logic [fhce_pkg::CLS_IDX_W-1:0] class_index;
    logic [fhce_pkg::CELL_W-1:0]    cell_length;
    logic                           no_data;
    logic                           last_result;
  } cell_beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [fhce_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [fhce_pkg::BOUND_W-1:0]   cfg_data = '0;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  logic [fhce_pkg::SAMPLE_W-1:0]  sample = '0;
  logic                           last = 1'b0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic [fhce_pkg::CLS_IDX_W-1:0] class_index;
  logic [fhce_pkg::CELL_W-1:0]    cell_length;
  logic                           no_data;
  logic                           last_result;

  longint unsigned              bin_tally [NUM_BINS];
  logic [fhce_pkg::BOUND_W-1:0] bounds [6];
  logic [fhce_pkg::MULT_W-1:0]  mult_start;
  cell_beat_t                   expected_cells [$];
  int                           errors = 0;
  int                           quiet_cycles = 0;
  bit                           gaps_on = 1'b1;
  bit                           stalls_on = 1'b1;

  flux_histogram_cell_estimator #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .class_index  (class_index),
    .cell_length  (cell_length),
    .no_data      (no_data),
    .last_result  (last_result)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    result_stall <= stalls_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("** flux_histogram_cell_estimator: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    cell_beat_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("result beat with nothing pending, class_index",
                        64'(class_index), 64'd0);
      end else begin
        want = expected_cells.pop_front();
        if (class_index !== want.class_index)
          report_mismatch("class_index", 64'(class_index), 64'(want.class_index));
        if (cell_length !== want.cell_length)
          report_mismatch("cell_length", 64'(cell_length), 64'(want.cell_length));
        if (no_data !== want.no_data)
          report_mismatch("no_data", 64'(no_data), 64'(want.no_data));
        if (last_result !== want.last_result)
          report_mismatch("last_result", 64'(last_result), 64'(want.last_result));
      end
    end
  end

  function automatic int bin_of(input logic [fhce_pkg::BOUND_W-1:0] b);
    return (int'(b) + 255) >> fhce_pkg::BIN_SHIFT;
  endfunction

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned top);
    if (a >= top || b >= top - a) return top;
    return a + b;
  endfunction

  // Close the block: sum class ranges, divide, queue three cell lengths.
  task automatic estimate_cells();
    longint unsigned wsum;
    longint unsigned cnt [3];
    longint unsigned divisor;
    longint unsigned base;
    longint unsigned m;
    longint unsigned cell_len;
    longint unsigned cell_top;
    cell_beat_t      beat;
    int              lo;
    int              hi;
    cell_top = 64'(fhce_pkg::CELL_MAX);
    wsum = 0;
    for (int i = 0; i < fhce_pkg::NUM_CLASSES; i++) begin
      cnt[i] = 0;
      lo = bin_of(bounds[2*i]);
      hi = bin_of(bounds[2*i+1]);
      for (int j = lo; j <= hi && j < NUM_BINS; j++) begin
        wsum = sat_add(wsum, (longint'(j) << fhce_pkg::BIN_SHIFT) * bin_tally[j],
                       64'(fhce_pkg::WSUM_MAX));
        cnt[i] = sat_add(cnt[i], bin_tally[j], 64'(fhce_pkg::CLASS_MAX));
      end
    end
    divisor = 64'(mult_start) * cnt[0] + (64'(mult_start) + 1) * cnt[1]
            + (64'(mult_start) + 2) * cnt[2];
    base = (divisor == 0) ? 0 : wsum / divisor;
    for (int i = 0; i < fhce_pkg::NUM_CLASSES; i++) begin
      m = 64'(mult_start) + 64'(i);
      if (base != 0 && m > cell_top / base) cell_len = cell_top;
      else cell_len = m * base;
      if (cell_len > cell_top) cell_len = cell_top;
      beat.class_index = fhce_pkg::CLS_IDX_W'(i);
      beat.cell_length = fhce_pkg::CELL_W'(cell_len);
      beat.no_data     = (divisor == 0);
      beat.last_result = (i == fhce_pkg::NUM_CLASSES - 1);
      expected_cells.push_back(beat);
    end
    for (int j = 0; j < NUM_BINS; j++) bin_tally[j] = 0;
  endtask

  task automatic send_beat(input logic [fhce_pkg::SAMPLE_W-1:0] s, input logic l);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      sample_valid <= 1'b0;
      sample       <= fhce_pkg::SAMPLE_W'($urandom_range(255));
      last         <= 1'($urandom_range(1));
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    last         <= l;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (l) begin
      estimate_cells();
    end else if (s[fhce_pkg::LEN_W-1:0] < NUM_BINS
                 && bin_tally[s[fhce_pkg::LEN_W-1:0]] < COUNT_SAT) begin
      bin_tally[s[fhce_pkg::LEN_W-1:0]]++;
    end
  endtask

  task automatic wait_until_drained();
    sample_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fhce_pkg::REG_IDX_W-1:0] idx,
                           input logic [fhce_pkg::BOUND_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == fhce_pkg::REG_MULT_START) mult_start = data[fhce_pkg::MULT_W-1:0];
    else if (idx != REG_UNUSED) bounds[idx] = data;
  endtask

  task automatic apply_config(input logic [fhce_pkg::BOUND_W-1:0] lo0, hi0, lo1, hi1,
                              lo2, hi2, mult);
    write_reg(fhce_pkg::REG_LOW_BOUND_0, lo0);
    write_reg(fhce_pkg::REG_HIGH_BOUND_0, hi0);
    write_reg(fhce_pkg::REG_LOW_BOUND_1, lo1);
    write_reg(fhce_pkg::REG_HIGH_BOUND_1, hi1);
    write_reg(fhce_pkg::REG_LOW_BOUND_2, lo2);
    write_reg(fhce_pkg::REG_HIGH_BOUND_2, hi2);
    write_reg(fhce_pkg::REG_MULT_START, mult);
    write_reg(REG_UNUSED, fhce_pkg::BOUND_W'($urandom_range(16'hffff)));
    cfg_write <= 1'b0;
  endtask

  task automatic random_range(output logic [fhce_pkg::BOUND_W-1:0] lo,
                              output logic [fhce_pkg::BOUND_W-1:0] hi);
    int pick;
    int lo_bin;
    int hi_bin;
    pick = $urandom_range(99);
    if (pick < 10) begin
      lo = fhce_pkg::BOUND_W'($urandom_range(16'hffff));
      hi = fhce_pkg::BOUND_W'($urandom_range(16'hffff));
    end else if (pick < 20) begin
      hi_bin = $urandom_range(0, 120);
      lo_bin = hi_bin + $urandom_range(1, 8);
      lo = fhce_pkg::BOUND_W'(lo_bin * 256 - $urandom_range(255));
      hi = (hi_bin == 0) ? '0 : fhce_pkg::BOUND_W'(hi_bin * 256 - $urandom_range(255));
    end else begin
      lo_bin = $urandom_range(0, NUM_BINS - 1);
      hi_bin = lo_bin + $urandom_range(0, 40);
      lo = (lo_bin == 0) ? '0 : fhce_pkg::BOUND_W'(lo_bin * 256 - $urandom_range(255));
      hi = (hi_bin == 0) ? '0 : fhce_pkg::BOUND_W'(hi_bin * 256 - $urandom_range(255));
    end
  endtask

  task automatic randomize_config();
    logic [fhce_pkg::BOUND_W-1:0] lo [3];
    logic [fhce_pkg::BOUND_W-1:0] hi [3];
    logic [fhce_pkg::BOUND_W-1:0] mult;
    for (int i = 0; i < fhce_pkg::NUM_CLASSES; i++) random_range(lo[i], hi[i]);
    mult = {(fhce_pkg::BOUND_W-fhce_pkg::MULT_W)'($urandom_range(16'h1fff)),
            fhce_pkg::MULT_W'($urandom_range(7))};
    if ($urandom_range(1)) mult[fhce_pkg::BOUND_W-1:fhce_pkg::MULT_W] = '0;
    apply_config(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], mult);
  endtask

  // Bias samples toward the configured class ranges so blocks give real estimates.
  function automatic logic [fhce_pkg::SAMPLE_W-1:0] pick_sample();
    int k;
    int lo;
    int hi;
    logic [fhce_pkg::SAMPLE_W-1:0] s;
    s = fhce_pkg::SAMPLE_W'($urandom_range(255));
    if ($urandom_range(99) < 75) begin
      k = $urandom_range(fhce_pkg::NUM_CLASSES - 1);
      lo = bin_of(bounds[2*k]);
      hi = bin_of(bounds[2*k+1]);
      if (hi >= NUM_BINS) hi = NUM_BINS - 1;
      if (lo <= hi) s[fhce_pkg::LEN_W-1:0] = fhce_pkg::LEN_W'($urandom_range(lo, hi));
    end
    return s;
  endfunction

  task automatic run_random_blocks(input int items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 40) begin
        wait_until_drained();
        randomize_config();
      end
      pick = $urandom_range(99);
      if (pick < 10) len = 0;
      else if (pick < 85) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 40);
      for (int i = 0; i < len; i++) send_beat(pick_sample(), 1'b0);
      send_beat(fhce_pkg::SAMPLE_W'($urandom_range(255)), 1'b1);
      sent += len + 1;
    end
  endtask

  task automatic test_default_config();
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7f, 1'b0);
    send_beat(8'hff, 1'b1);
  endtask

  task automatic test_zero_divisor();
    send_beat(8'h00, 1'b1);
  endtask

  // Multiple zero with a heavy class 0 and one count in class 1 drives the cell past 18 bits.
  task automatic test_saturated_cell();
    wait_until_drained();
    apply_config(16'h7f00, 16'h7f00, 16'h0001, 16'h0100, 16'hffff, 16'h0000, 16'h0000);
    for (int i = 0; i < 10; i++) send_beat(8'h7f, 1'b0);
    send_beat(8'h81, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_full_bounds();
    wait_until_drained();
    apply_config(16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'hffff);
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'haa, 1'b0);
    send_beat(8'h01, 1'b1);
  endtask

  task automatic test_streaming_blocks();
    wait_until_drained();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_random_blocks(80);
    wait_until_drained();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_blocks();
    run_random_blocks(220);
  endtask

  initial begin
    for (int j = 0; j < NUM_BINS; j++) bin_tally[j] = 0;
    for (int i = 0; i < 6; i++) bounds[i] = '0;
    mult_start = fhce_pkg::MULT_START_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_config();
    test_zero_divisor();
    test_saturated_cell();
    test_full_bounds();
    test_streaming_blocks();
    test_random_blocks();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("** flux_histogram_cell_estimator: PASSED **");
    end else begin
      $display("** flux_histogram_cell_estimator: FAILED **");
    end
    $finish;
  end

endmodule
